>>> hw/rtl/pod_pkg.sv
package pod_pkg;

    // register map, index = byte address / 4
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT_Z  = 3'd6;

    localparam logic [15:0] RST_NEAR_LIMIT  = 16'd10000;
    localparam logic [15:0] RST_MIN_VALID   = 16'd100;
    localparam logic [15:0] RST_MAX_VALID   = 16'd50000;
    localparam logic [7:0]  RST_DEBOUNCE    = 8'd3;
    localparam logic [15:0] RST_MAG_LIMIT_X = 16'd100;
    localparam logic [15:0] RST_MAG_LIMIT_Y = 16'd49;
    localparam logic [15:0] RST_MAG_LIMIT_Z = 16'd349;

    localparam logic [7:0] RUN_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] near_limit;
        logic [15:0] min_valid_distance;
        logic [15:0] max_valid_distance;
        logic [7:0]  debounce_count;
        logic [15:0] mag_limit_x;
        logic [15:0] mag_limit_y;
        logic [15:0] mag_limit_z;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        distance;
        logic               distance_invalid;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
    } t_item;

    typedef struct packed {
        logic occupied;
        logic used_magnetic;
        logic baseline_taken;
        logic magnetic_event;
    } t_result;

endpackage

>>> hw/rtl/pod_cfg_regs.sv
module pod_cfg_regs
    import pod_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [CFG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit         <= RST_NEAR_LIMIT;
            r_cfg.min_valid_distance <= RST_MIN_VALID;
            r_cfg.max_valid_distance <= RST_MAX_VALID;
            r_cfg.debounce_count     <= RST_DEBOUNCE;
            r_cfg.mag_limit_x        <= RST_MAG_LIMIT_X;
            r_cfg.mag_limit_y        <= RST_MAG_LIMIT_Y;
            r_cfg.mag_limit_z        <= RST_MAG_LIMIT_Z;
        end else if (w_wr) begin
            case (w_idx)
                REG_NEAR_LIMIT:  r_cfg.near_limit         <= pwdata[15:0];
                REG_MIN_VALID:   r_cfg.min_valid_distance <= pwdata[15:0];
                REG_MAX_VALID:   r_cfg.max_valid_distance <= pwdata[15:0];
                REG_DEBOUNCE:    r_cfg.debounce_count     <= pwdata[7:0];
                REG_MAG_LIMIT_X: r_cfg.mag_limit_x        <= pwdata[15:0];
                REG_MAG_LIMIT_Y: r_cfg.mag_limit_y        <= pwdata[15:0];
                REG_MAG_LIMIT_Z: r_cfg.mag_limit_z        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NEAR_LIMIT:  prdata = {16'd0, r_cfg.near_limit};
            REG_MIN_VALID:   prdata = {16'd0, r_cfg.min_valid_distance};
            REG_MAX_VALID:   prdata = {16'd0, r_cfg.max_valid_distance};
            REG_DEBOUNCE:    prdata = {24'd0, r_cfg.debounce_count};
            REG_MAG_LIMIT_X: prdata = {16'd0, r_cfg.mag_limit_x};
            REG_MAG_LIMIT_Y: prdata = {16'd0, r_cfg.mag_limit_y};
            REG_MAG_LIMIT_Z: prdata = {16'd0, r_cfg.mag_limit_z};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/pod_track.sv
module pod_track
    import pod_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [7:0]  r_near_run, n_near_run;
    logic [7:0]  r_far_run,  n_far_run;
    logic        r_occ,      n_occ;
    logic [15:0] r_base_x,   n_base_x;
    logic [15:0] r_base_y,   n_base_y;
    logic [15:0] r_base_z,   n_base_z;

    logic        w_valid;
    logic        w_near;
    logic        w_base_zero;
    logic signed [16:0] w_dx, w_dy, w_dz;
    logic [16:0] w_ax, w_ay, w_az;
    logic        w_event;

    // distance window
    assign w_valid = !i_item.distance_invalid
                     && (i_item.distance > i_cfg.min_valid_distance)
                     && (i_item.distance <= i_cfg.max_valid_distance);
    assign w_near  = i_item.distance < i_cfg.near_limit;

    // per-axis |reading - baseline|, 17 bits covers the full span
    assign w_dx = {i_item.field_x[15], i_item.field_x} - $signed({r_base_x[15], r_base_x});
    assign w_dy = {i_item.field_y[15], i_item.field_y} - $signed({r_base_y[15], r_base_y});
    assign w_dz = {i_item.field_z[15], i_item.field_z} - $signed({r_base_z[15], r_base_z});
    assign w_ax = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ay = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    assign w_az = w_dz[16] ? 17'(-w_dz) : 17'(w_dz);

    assign w_base_zero = (r_base_x == 16'd0) && (r_base_y == 16'd0) && (r_base_z == 16'd0);
    assign w_event = !w_base_zero
                     && ((w_ax > {1'b0, i_cfg.mag_limit_x})
                      || (w_ay > {1'b0, i_cfg.mag_limit_y})
                      || (w_az > {1'b0, i_cfg.mag_limit_z}));

    always_comb begin
        n_near_run = r_near_run;
        n_far_run  = r_far_run;
        n_occ      = r_occ;
        n_base_x   = r_base_x;
        n_base_y   = r_base_y;
        n_base_z   = r_base_z;
        if (w_valid) begin
            if (w_near) begin
                n_near_run = (r_near_run == RUN_MAX) ? RUN_MAX : r_near_run + 8'd1;
                n_far_run  = 8'd0;
            end else begin
                n_far_run  = (r_far_run == RUN_MAX) ? RUN_MAX : r_far_run + 8'd1;
                n_near_run = 8'd0;
            end
            // only one run is nonzero, so at most one of these fires
            if (n_near_run > i_cfg.debounce_count) begin
                n_occ = 1'b1;
            end else if (n_far_run > i_cfg.debounce_count) begin
                n_occ = 1'b0;
            end
        end else if (w_base_zero || w_event) begin
            n_base_x = i_item.field_x;
            n_base_y = i_item.field_y;
            n_base_z = i_item.field_z;
            if (w_event) begin
                n_occ = !r_occ;
            end
        end
    end

    always_comb begin
        o_res.occupied       = n_occ;
        o_res.used_magnetic  = !w_valid;
        o_res.baseline_taken = !w_valid && w_base_zero;
        o_res.magnetic_event = !w_valid && w_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_run <= 8'd0;
            r_far_run  <= 8'd0;
            r_occ      <= 1'b0;
            r_base_x   <= 16'd0;
            r_base_y   <= 16'd0;
            r_base_z   <= 16'd0;
        end else if (i_adv) begin
            r_near_run <= n_near_run;
            r_far_run  <= n_far_run;
            r_occ      <= n_occ;
            r_base_x   <= n_base_x;
            r_base_y   <= n_base_y;
            r_base_z   <= n_base_z;
        end
    end

endmodule

>>> hw/rtl/parking_occupancy_detector_core.sv
// Parking spot occupancy detector. Each request on the slave stream is one
// sensor tick (a distance sample plus a 3-axis magnetometer reading) and
// produces exactly one result on the master stream. A distance inside the
// configured window drives debounced near/far run counters; otherwise the
// magnetic path captures a baseline or flags a field change that toggles
// occupancy. Throughput is one request per clock while the master side takes
// results: a request is held in the input register, the decision logic and
// state update run between that register and the result register, and
// o_m_tvalid rises when the result register is loaded. A stalled master side
// backs up through the two registers; the slave side keeps accepting as
// long as either has room.
// Configuration is through the APB port (7 registers at byte address 4*i)
// and should only be changed while no request is in flight.
module parking_occupancy_detector_core
    import pod_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [63:0]           i_s_tdata,  // distance[15:0], field_x, field_y, field_z
    input  logic                  i_s_tuser,  // distance_invalid
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,  // occupied, baseline_taken, magnetic_event, 0
    output logic                  o_m_tuser,  // used_magnetic
    // APB config
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result w_res;
    logic    w_adv;

    pod_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register moves into result register whenever there is room
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    pod_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.distance         <= i_s_tdata[15:0];
            r_in.distance_invalid <= i_s_tuser;
            r_in.field_x          <= i_s_tdata[31:16];
            r_in.field_y          <= i_s_tdata[47:32];
            r_in.field_z          <= i_s_tdata[63:48];
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.magnetic_event, r_out.baseline_taken, r_out.occupied};
    assign o_m_tuser  = r_out.used_magnetic;

    // a held request must not change while waiting for the result register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("input register lost or changed a waiting request");

    // distance-path results never report baseline or event
    a_dist_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[2:1] == 2'b00)
        else $error("distance result carries magnetic flags");

    // baseline capture and event are exclusive
    a_mag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[1] && o_m_tdata[2]))
        else $error("baseline capture and magnetic event together");

endmodule

>>> tb/sv/tb_parking_occupancy_detector_core.sv
module tb_parking_occupancy_detector_core;
    import pod_pkg::*;

    // cycles without any request moving on either stream or the APB port
    localparam int WATCHDOG_LIMIT = 1000;

    // flavor of a generated sensor tick
    typedef enum int {
        TICK_NEAR,   // distance inside the window, below near_limit
        TICK_FAR,    // distance inside the window, at or above near_limit
        TICK_EDGE,   // distance on a window or near_limit boundary, or 0 or 16'hFFFF
        TICK_MAG,    // distance rejected, field around the stored baseline, zero or random
        TICK_WILD    // anything
    } t_tick_kind;

    // Occupancy predictor plus the queue of results it expects, oldest first.
    class t_occupancy_scoreboard;
        t_cfg               cfg;
        logic [7:0]         near_run;
        logic [7:0]         far_run;
        logic               occupied;
        logic signed [15:0] base_x;
        logic signed [15:0] base_y;
        logic signed [15:0] base_z;
        t_result            expected_q[$];
        int                 errors;
        int                 ticks;
        int                 results;
        int                 mag_ticks;
        int                 baselines;
        int                 field_events;

        function new();
            cfg.near_limit         = RST_NEAR_LIMIT;
            cfg.min_valid_distance = RST_MIN_VALID;
            cfg.max_valid_distance = RST_MAX_VALID;
            cfg.debounce_count     = RST_DEBOUNCE;
            cfg.mag_limit_x        = RST_MAG_LIMIT_X;
            cfg.mag_limit_y        = RST_MAG_LIMIT_Y;
            cfg.mag_limit_z        = RST_MAG_LIMIT_Z;
            near_run     = '0;
            far_run      = '0;
            occupied     = 1'b0;
            base_x       = '0;
            base_y       = '0;
            base_z       = '0;
            errors       = 0;
            ticks        = 0;
            results      = 0;
            mag_ticks    = 0;
            baselines    = 0;
            field_events = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_NEAR_LIMIT:  cfg.near_limit         = value[15:0];
                REG_MIN_VALID:   cfg.min_valid_distance = value[15:0];
                REG_MAX_VALID:   cfg.max_valid_distance = value[15:0];
                REG_DEBOUNCE:    cfg.debounce_count     = value[7:0];
                REG_MAG_LIMIT_X: cfg.mag_limit_x        = value[15:0];
                REG_MAG_LIMIT_Y: cfg.mag_limit_y        = value[15:0];
                REG_MAG_LIMIT_Z: cfg.mag_limit_z        = value[15:0];
                default: ;
            endcase
        endfunction

        function int field_delta(logic signed [15:0] a, logic signed [15:0] b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted tick, queue its result.
        function void note_tick(t_item it);
            t_result r;
            logic    in_window;
            r = '0;
            in_window = !it.distance_invalid
                        && it.distance > cfg.min_valid_distance
                        && it.distance <= cfg.max_valid_distance;
            ticks++;
            if (in_window) begin
                if (it.distance < cfg.near_limit) begin
                    if (near_run != RUN_MAX) near_run = near_run + 8'd1;
                    far_run = '0;
                end else begin
                    if (far_run != RUN_MAX) far_run = far_run + 8'd1;
                    near_run = '0;
                end
                if (near_run > cfg.debounce_count) occupied = 1'b1;
                if (far_run > cfg.debounce_count) occupied = 1'b0;
            end else begin
                mag_ticks++;
                if (base_x == 0 && base_y == 0 && base_z == 0) begin
                    // empty baseline: capture, even an all-zero reading
                    base_x = it.field_x;
                    base_y = it.field_y;
                    base_z = it.field_z;
                    r.baseline_taken = 1'b1;
                    baselines++;
                end else if (field_delta(base_x, it.field_x) > int'(cfg.mag_limit_x)
                          || field_delta(base_y, it.field_y) > int'(cfg.mag_limit_y)
                          || field_delta(base_z, it.field_z) > int'(cfg.mag_limit_z)) begin
                    base_x = it.field_x;
                    base_y = it.field_y;
                    base_z = it.field_z;
                    occupied = !occupied;
                    r.magnetic_event = 1'b1;
                    field_events++;
                end
            end
            r.occupied      = occupied;
            r.used_magnetic = !in_window;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic got, logic want);
            if (got !== want)
                report($sformatf("result %0d %s: got %b, expected %b",
                                 results, name, got, want));
        endtask

        task check_result(logic [7:0] data, logic used_mag);
            t_result want;
            results++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with no tick outstanding", results));
                return;
            end
            want = expected_q.pop_front();
            compare_field("occupied", data[0], want.occupied);
            compare_field("used_magnetic", used_mag, want.used_magnetic);
            compare_field("baseline_taken", data[1], want.baseline_taken);
            compare_field("magnetic_event", data[2], want.magnetic_event);
            if (data[7:3] !== 5'd0)
                report($sformatf("result %0d pad bits not zero: %b", results, data[7:3]));
        endtask
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [63:0]           i_s_tdata  = '0;   // distance, field_x, field_y, field_z
    logic                  i_s_tuser  = 1'b0; // distance_invalid
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;         // occupied, baseline_taken, magnetic_event, pad
    logic                  o_m_tuser;         // used_magnetic
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    t_occupancy_scoreboard sb;
    int                    burst_left  = 0;
    int                    idle_cycles = 0;
    logic [15:0]           ready_pat   = 16'hFFFF;
    int                    pat_age     = 0;

    parking_occupancy_detector_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side back-pressure: a rotating 16-bit pattern that is replaced
    // periodically. Bit 0 is always set in a new pattern, so a stall never
    // outlasts one turn of the pattern; all-ones gives clean stretches.
    always @(negedge i_clk) begin
        i_m_tready <= ready_pat[0];
        if (pat_age == 47) begin
            pat_age <= 0;
            case ($urandom_range(3))
                0:       ready_pat <= 16'hFFFF;
                1:       ready_pat <= 16'h0001;
                default: ready_pat <= 16'($urandom) | 16'h0001;
            endcase
        end else begin
            pat_age   <= pat_age + 1;
            ready_pat <= {ready_pat[0], ready_pat[15:1]};
        end
    end

    // every result request is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_item tick_of(logic [15:0] range_val, logic inv, logic [15:0] x,
                                      logic [15:0] y, logic [15:0] z);
        t_item it;
        it.distance         = range_val;
        it.distance_invalid = inv;
        it.field_x          = x;
        it.field_y          = y;
        it.field_z          = z;
        return it;
    endfunction

    function automatic t_cfg make_cfg(logic [15:0] near, logic [15:0] lo, logic [15:0] hi,
                                      logic [7:0] deb, logic [15:0] mx, logic [15:0] my,
                                      logic [15:0] mz);
        t_cfg c;
        c.near_limit         = near;
        c.min_valid_distance = lo;
        c.max_valid_distance = hi;
        c.debounce_count     = deb;
        c.mag_limit_x        = mx;
        c.mag_limit_y        = my;
        c.mag_limit_z        = mz;
        return c;
    endfunction

    // offset either just around the axis limit or between zero and it (at most 1000), random sign
    function automatic logic [15:0] jitter(logic [15:0] lim);
        int off;
        if ($urandom_range(1) != 0)
            off = int'(lim) - 2 + int'($urandom_range(4));
        else
            off = int'($urandom_range((lim > 16'd1000) ? 1000 : int'(lim)));
        if ($urandom_range(1) != 0)
            off = -off;
        return 16'(off);
    endfunction

    function automatic t_tick_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return TICK_NEAR;
        if (r < 60) return TICK_FAR;
        if (r < 85) return TICK_MAG;
        if (r < 95) return TICK_EDGE;
        return TICK_WILD;
    endfunction

    function automatic t_item make_tick(t_tick_kind kind);
        t_item it;
        int    mn;
        int    mx;
        int    nl;
        int    lo;
        int    hi;
        int    pick;
        mn = sb.cfg.min_valid_distance;
        mx = sb.cfg.max_valid_distance;
        nl = sb.cfg.near_limit;
        it.distance         = 16'($urandom);
        it.distance_invalid = 1'b0;
        it.field_x          = 16'($urandom);
        it.field_y          = 16'($urandom);
        it.field_z          = 16'($urandom);
        case (kind)
            TICK_NEAR: begin
                lo = mn + 1;
                hi = (nl - 1 < mx) ? nl - 1 : mx;
                if (lo <= hi) it.distance = 16'($urandom_range(hi, lo));
            end
            TICK_FAR: begin
                lo = (mn + 1 > nl) ? mn + 1 : nl;
                hi = mx;
                if (lo <= hi) it.distance = 16'($urandom_range(hi, lo));
            end
            TICK_EDGE: begin
                case ($urandom_range(7))
                    0:       it.distance = 16'(mn);
                    1:       it.distance = 16'(mn + 1);
                    2:       it.distance = 16'(mx);
                    3:       it.distance = 16'(mx + 1);
                    4:       it.distance = 16'(nl - 1);
                    5:       it.distance = 16'(nl);
                    6:       it.distance = 16'd0;
                    default: it.distance = 16'hFFFF;
                endcase
                it.distance_invalid = ($urandom_range(9) == 0);
            end
            TICK_MAG: begin
                // reject the distance either by the flag or by the window
                it.distance_invalid = ($urandom_range(2) != 0);
                if (!it.distance_invalid)
                    it.distance = ($urandom_range(1) != 0 || mx == 65535) ? 16'(mn)
                                                                          : 16'(mx + 1);
                pick = $urandom_range(9);
                if (pick < 4) begin
                    it.field_x = sb.base_x + jitter(sb.cfg.mag_limit_x);
                    it.field_y = sb.base_y + jitter(sb.cfg.mag_limit_y);
                    it.field_z = sb.base_z + jitter(sb.cfg.mag_limit_z);
                end else if (pick == 4) begin
                    it.field_x = sb.base_x;
                    it.field_y = sb.base_y;
                    it.field_z = sb.base_z;
                end else if (pick == 5) begin
                    // all-zero reading: an event here empties the baseline
                    it.field_x = '0;
                    it.field_y = '0;
                    it.field_z = '0;
                end
            end
            default: it.distance_invalid = 1'($urandom_range(1));
        endcase
        return it;
    endfunction

    // One tick request, then the sender's burst/gap bookkeeping.
    // Called and returns just after a falling edge.
    task automatic push_tick(t_item it);
        int gap;
        i_s_tdata  <= {it.field_z, it.field_y, it.field_x, it.distance};
        i_s_tuser  <= it.distance_invalid;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_tick(it);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 1);
        end
    endtask

    // Runs of like ticks: the kind is redrawn with switch_pct percent chance,
    // so debounce runs actually build up.
    task automatic run_ticks(int count, int switch_pct, t_tick_kind first);
        t_tick_kind kind;
        kind = first;
        for (int i = 0; i < count; i++) begin
            if (i != 0 && $urandom_range(99) < switch_pct)
                kind = pick_kind();
            push_tick(make_tick(kind));
        end
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(REG_NEAR_LIMIT, {16'd0, c.near_limit});
        write_reg(REG_MIN_VALID, {16'd0, c.min_valid_distance});
        write_reg(REG_MAX_VALID, {16'd0, c.max_valid_distance});
        write_reg(REG_DEBOUNCE, {24'd0, c.debounce_count});
        write_reg(REG_MAG_LIMIT_X, {16'd0, c.mag_limit_x});
        write_reg(REG_MAG_LIMIT_Y, {16'd0, c.mag_limit_y});
        write_reg(REG_MAG_LIMIT_Z, {16'd0, c.mag_limit_z});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed, reset configuration ---
        // zero reading as baseline keeps the baseline empty, so capture again
        push_tick(tick_of(16'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
        push_tick(tick_of(16'd0, 1'b1, 16'h8000, 16'h7FFF, 16'h0001));
        push_tick(tick_of(16'd0, 1'b1, 16'h8000, 16'h7FFF, 16'h0001));
        // x delta exactly at the limit, then one past it
        push_tick(tick_of(16'd0, 1'b1, 16'h8064, 16'h7FFF, 16'h0001));
        push_tick(tick_of(16'd0, 1'b1, 16'h8065, 16'h7FFF, 16'h0001));
        // distance at min fails, just over max fails; y one past its limit
        push_tick(tick_of(16'd100, 1'b0, 16'h8065, 16'h7FFF, 16'h0001));
        push_tick(tick_of(16'd50001, 1'b0, 16'h8065, 16'h7FCD, 16'h0001));
        // z exactly at the limit, then one past it
        push_tick(tick_of(16'd0, 1'b0, 16'h8065, 16'h7FCD, 16'h015E));
        push_tick(tick_of(16'hFFFF, 1'b1, 16'h8065, 16'h7FCD, 16'h015F));
        // far run at max distance empties the spot on the fourth tick
        repeat (4) push_tick(tick_of(16'd50000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        // near run broken by distance == near_limit, then a full near run
        push_tick(tick_of(16'd101, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_tick(tick_of(16'd9999, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        push_tick(tick_of(16'd101, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        push_tick(tick_of(16'd10000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        repeat (4) push_tick(tick_of(16'd9999, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        // field extremes on the magnetic path
        push_tick(tick_of(16'hFFFF, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        push_tick(tick_of(16'd0, 1'b1, 16'h8000, 16'h8000, 16'h8000));
        wait_idle();

        // --- random phases, one register setting each ---
        apply_cfg(make_cfg(16'd10000, 16'd100, 16'd50000, 8'd3, 16'd100, 16'd49, 16'd349));
        run_ticks(100, 15, TICK_NEAR);
        wait_idle();

        // zero debounce and zero magnetic limits: every change counts
        apply_cfg(make_cfg(16'd2000, 16'd0, 16'hFFFF, 8'd0, 16'd0, 16'd0, 16'd0));
        run_ticks(100, 25, TICK_MAG);
        wait_idle();

        // widest window, limits at full scale: no magnetic event possible
        apply_cfg(make_cfg(16'hFFFF, 16'd0, 16'hFFFF, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        run_ticks(80, 15, TICK_FAR);
        wait_idle();

        // inverted window: every tick takes the magnetic path
        apply_cfg(make_cfg(16'd0, 16'hFFFF, 16'd0, 8'd2, 16'd500, 16'd1, 16'hFFFF));
        run_ticks(80, 15, TICK_WILD);
        wait_idle();

        // debounce of 254: a near run that reaches saturation, then far ticks
        apply_cfg(make_cfg(16'd10000, 16'd100, 16'd50000, 8'd254, 16'd100, 16'd49, 16'd349));
        run_ticks(262, 0, TICK_NEAR);
        run_ticks(20, 0, TICK_FAR);
        wait_idle();

        // debounce of 255: saturated runs can never flip occupancy
        apply_cfg(make_cfg(16'd10000, 16'd100, 16'd50000, 8'd255, 16'd100, 16'd49, 16'd349));
        run_ticks(40, 5, TICK_FAR);
        wait_idle();

        apply_cfg(make_cfg(16'($urandom), 16'($urandom_range(2000)),
                           16'($urandom_range(65535, 20000)), 8'($urandom_range(6)),
                           16'($urandom_range(300)), 16'($urandom_range(300)),
                           16'($urandom_range(300))));
        run_ticks(100, 15, TICK_MAG);
        wait_idle();

        repeat (4) @(negedge i_clk);
        $display("covered %0d ticks over 8 register settings: %0d magnetic,",
                 sb.ticks, sb.mag_ticks);
        $display("%0d baselines, %0d field events, %0d results checked, %0d mismatches",
                 sb.baselines, sb.field_events, sb.results, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
